// ===== hdl/ste_pkg.sv =====
// ----------------------------------------------------------------------------
// ste_pkg - shared types and constants of the substitution template expander
// Character codes, command words passed from the front end to the back end,
// and the case conversion used on emitted letters.
// ----------------------------------------------------------------------------
package ste_pkg;

  localparam int MATCH_DEPTH = 64;
  localparam int GROUP_COUNT = 10;
  localparam int MATCH_AW    = (MATCH_DEPTH > 1) ? $clog2(MATCH_DEPTH) : 1;
  localparam int GROUP_AW    = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int POS_W       = 6;
  localparam int SPAN_W      = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // input operations
  localparam logic [1:0] OP_LOAD_BYTE = 2'd0;
  localparam logic [1:0] OP_LOAD_SPAN = 2'd1;
  localparam logic [1:0] OP_TEMPLATE  = 2'd2;

  // case modes
  localparam logic [1:0] CASE_NONE  = 2'd0;
  localparam logic [1:0] CASE_UPPER = 2'd1;
  localparam logic [1:0] CASE_LOWER = 2'd2;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BSP    = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_DIG0   = 8'h30;
  localparam logic [7:0] CH_DIG9   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_UP_L   = 8'h4C;
  localparam logic [7:0] CH_UP_U   = 8'h55;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_L   = 8'h6C;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_U   = 8'h75;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CASE_DIST = 8'h20;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_LOAD_BYTE,
    CMD_LOAD_SPAN,
    CMD_LIT,
    CMD_RAW,
    CMD_COPY,
    CMD_STICKY,
    CMD_ONESHOT
  } cmd_kind_e;

  // data holds the byte, the group number or the case mode, by kind
  typedef struct packed {
    cmd_kind_e          kind;
    logic [POS_W-1:0]   position;
    logic [7:0]         data;
    logic [SPAN_W-1:0]  span_start;
    logic [SPAN_W-1:0]  span_end;
    logic               span_valid;
    logic               last;
  } cmd_t;

  function automatic logic [7:0] apply_case(input logic [7:0] c, input logic [1:0] dir);
    logic [7:0] r;
    r = c;
    if (dir == CASE_LOWER && c >= CH_UP_A && c <= CH_UP_Z) begin
      r = c + CASE_DIST;
    end else if (dir == CASE_UPPER && c >= CH_LO_A && c <= CH_LO_Z) begin
      r = c - CASE_DIST;
    end
    return r;
  endfunction

endpackage

// ===== hdl/ste_front.sv =====
// ----------------------------------------------------------------------------
// ste_front - input decoder
// Accepts input words, tracks the escape state and turns each word into at
// most one command for the back end.
// ----------------------------------------------------------------------------
module ste_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        in_op_i,
  input  logic [28:0]       in_data_i,
  input  logic              in_last_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output ste_pkg::cmd_t     q_cmd_o
);

  logic          esc_q, esc_d;
  logic          accept;
  logic [7:0]    ch;
  ste_pkg::cmd_t cmd;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign ch         = in_data_i[13:6];

  always_comb begin
    cmd.kind       = ste_pkg::CMD_NOP;
    cmd.position   = in_data_i[5:0];
    cmd.data       = ch;
    cmd.span_start = in_data_i[20:14];
    cmd.span_end   = in_data_i[27:21];
    cmd.span_valid = in_data_i[28];
    cmd.last       = in_last_i && (in_op_i == ste_pkg::OP_TEMPLATE);
    esc_d          = esc_q;
    unique case (in_op_i)
      ste_pkg::OP_LOAD_BYTE: begin
        if ({1'b0, cmd.position} < 7'(ste_pkg::MATCH_DEPTH)) begin
          cmd.kind = ste_pkg::CMD_LOAD_BYTE;
        end
      end
      ste_pkg::OP_LOAD_SPAN: begin
        if ({1'b0, cmd.position} < 7'(ste_pkg::GROUP_COUNT)) begin
          cmd.kind = ste_pkg::CMD_LOAD_SPAN;
        end
      end
      ste_pkg::OP_TEMPLATE: begin
        if (esc_q) begin
          esc_d = 1'b0;
          if (ch >= ste_pkg::CH_DIG0 && ch <= ste_pkg::CH_DIG9) begin
            cmd.kind = ste_pkg::CMD_COPY;
            cmd.data = ch - ste_pkg::CH_DIG0;
          end else begin
            unique case (ch)
              ste_pkg::CH_NUL: cmd.kind = ste_pkg::CMD_NOP;
              ste_pkg::CH_UP_U: begin
                cmd.kind = ste_pkg::CMD_STICKY;
                cmd.data = {6'd0, ste_pkg::CASE_UPPER};
              end
              ste_pkg::CH_UP_L: begin
                cmd.kind = ste_pkg::CMD_STICKY;
                cmd.data = {6'd0, ste_pkg::CASE_LOWER};
              end
              ste_pkg::CH_UP_E, ste_pkg::CH_LO_E: begin
                cmd.kind = ste_pkg::CMD_STICKY;
                cmd.data = {6'd0, ste_pkg::CASE_NONE};
              end
              ste_pkg::CH_LO_U: begin
                cmd.kind = ste_pkg::CMD_ONESHOT;
                cmd.data = {6'd0, ste_pkg::CASE_UPPER};
              end
              ste_pkg::CH_LO_L: begin
                cmd.kind = ste_pkg::CMD_ONESHOT;
                cmd.data = {6'd0, ste_pkg::CASE_LOWER};
              end
              ste_pkg::CH_LO_B: begin
                cmd.kind = ste_pkg::CMD_RAW;
                cmd.data = ste_pkg::CH_BSP;
              end
              ste_pkg::CH_LO_F: begin
                cmd.kind = ste_pkg::CMD_RAW;
                cmd.data = ste_pkg::CH_FF;
              end
              ste_pkg::CH_LO_R: begin
                cmd.kind = ste_pkg::CMD_RAW;
                cmd.data = ste_pkg::CH_CR;
              end
              ste_pkg::CH_LO_T: begin
                cmd.kind = ste_pkg::CMD_RAW;
                cmd.data = ste_pkg::CH_TAB;
              end
              ste_pkg::CH_LO_N: begin
                cmd.kind = ste_pkg::CMD_RAW;
                cmd.data = ste_pkg::CH_NL;
              end
              default: cmd.kind = ste_pkg::CMD_RAW;
            endcase
          end
        end else begin
          unique case (ch)
            ste_pkg::CH_NUL:    cmd.kind = ste_pkg::CMD_NOP;
            ste_pkg::CH_BSLASH: esc_d = 1'b1;
            ste_pkg::CH_AMP: begin
              cmd.kind = ste_pkg::CMD_COPY;
              cmd.data = 8'd0;
            end
            ste_pkg::CH_NL, ste_pkg::CH_CR: begin
              cmd.kind = ste_pkg::CMD_RAW;
              cmd.data = ste_pkg::CH_NL;
            end
            default: cmd.kind = ste_pkg::CMD_LIT;
          endcase
        end
        // drop a trailing lone backslash
        if (in_last_i) begin
          esc_d = 1'b0;
        end
      end
      default: cmd.kind = ste_pkg::CMD_NOP;
    endcase
  end

  // a plain drop still travels when it closes the template
  assign q_push_o = accept && (cmd.kind != ste_pkg::CMD_NOP || cmd.last);
  assign q_cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
    end else if (accept) begin
      esc_q <= esc_d;
    end
  end

endmodule

// ===== hdl/ste_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// ste_cmd_fifo - command queue
// Short queue between decoder and executor so that each side stalls alone.
// ----------------------------------------------------------------------------
module ste_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ste_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ste_pkg::cmd_t cmd_o
);

  ste_pkg::cmd_t                   mem_q [ste_pkg::QUEUE_DEPTH];
  logic [ste_pkg::QUEUE_AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [ste_pkg::QUEUE_AW:0]      count_q;
  logic                            do_push, do_pop;

  assign full_o  = (count_q == (ste_pkg::QUEUE_AW+1)'(ste_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== hdl/ste_back.sv =====
// ----------------------------------------------------------------------------
// ste_back - command executor
// Holds the match store and group tables, applies case modes, streams group
// copies one byte per cycle while the output is not stalled and drives the output register.
// ----------------------------------------------------------------------------
module ste_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  ste_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          out_error_o,
  output logic          out_last_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_COPY = 1'b1;

  logic [7:0]                   match_mem [ste_pkg::MATCH_DEPTH];
  logic [7:0]                   rd_data_q;
  logic [ste_pkg::MATCH_AW-1:0] rd_addr;
  logic                         mem_we;

  logic [ste_pkg::SPAN_W-1:0]   grp_start_q [ste_pkg::GROUP_COUNT];
  logic [ste_pkg::SPAN_W-1:0]   grp_end_q   [ste_pkg::GROUP_COUNT];
  logic [ste_pkg::GROUP_COUNT-1:0] grp_valid_q, grp_valid_d;
  logic                         tbl_we;
  logic [ste_pkg::GROUP_AW-1:0] wr_grp, rd_grp;
  logic                         grp_in_range;
  logic [ste_pkg::SPAN_W-1:0]   sel_start, sel_end;
  logic                         sel_valid;

  logic                         state_q, state_d;
  logic [ste_pkg::SPAN_W-1:0]   addr_q, addr_d, end_q, end_d;
  logic                         last_q, last_d;
  logic [1:0]                   sticky_q, sticky_d, oneshot_q, oneshot_d;
  logic                         failed_q, failed_d;

  logic                         out_valid_q, out_valid_d;
  logic [7:0]                   out_byte_q, out_byte_d;
  logic                         out_error_q, out_error_d;
  logic                         out_last_q, out_last_d;

  logic                         out_free;
  logic [1:0]                   case_dir;
  logic                         case_active;
  logic                         copy_last;
  logic                         copy_adv;
  logic                         done, done_last;

  assign out_free    = !out_valid_q || out_ready_i;
  assign case_active = (oneshot_q != ste_pkg::CASE_NONE) || (sticky_q != ste_pkg::CASE_NONE);
  assign case_dir    = (oneshot_q != ste_pkg::CASE_NONE) ? oneshot_q : sticky_q;
  assign copy_last   = ((addr_q + 1'b1) == end_q);
  assign copy_adv    = (state_q == S_COPY) && out_free && (rd_data_q != ste_pkg::CH_NUL)
                       && !copy_last;

  // group table read, guarded against numbers past the table
  assign grp_in_range = (q_cmd_i.data < 8'(ste_pkg::GROUP_COUNT));
  assign rd_grp       = grp_in_range ? q_cmd_i.data[ste_pkg::GROUP_AW-1:0] : '0;
  assign wr_grp       = q_cmd_i.position[ste_pkg::GROUP_AW-1:0];
  assign sel_start    = grp_start_q[rd_grp];
  assign sel_end      = grp_end_q[rd_grp];
  assign sel_valid    = grp_in_range && grp_valid_q[rd_grp];

  always_comb begin
    if (state_q == S_COPY) begin
      rd_addr = copy_adv ? ste_pkg::MATCH_AW'(addr_q + 1'b1)
                         : ste_pkg::MATCH_AW'(addr_q);
    end else begin
      rd_addr = ste_pkg::MATCH_AW'(sel_start);
    end
  end

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    end_d       = end_q;
    last_d      = last_q;
    sticky_d    = sticky_q;
    oneshot_d   = oneshot_q;
    failed_d    = failed_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_error_d = out_error_q;
    out_last_d  = out_last_q;
    grp_valid_d = grp_valid_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    tbl_we      = 1'b0;
    done        = 1'b0;
    done_last   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          done_last = q_cmd_i.last;
          priority if (q_cmd_i.kind == ste_pkg::CMD_LOAD_BYTE) begin
            mem_we  = 1'b1;
            q_pop_o = 1'b1;
          end else if (q_cmd_i.kind == ste_pkg::CMD_LOAD_SPAN) begin
            tbl_we              = 1'b1;
            grp_valid_d[wr_grp] = q_cmd_i.span_valid;
            q_pop_o             = 1'b1;
          end else if (failed_q) begin
            // drop template work until the template ends
            q_pop_o = 1'b1;
            done    = 1'b1;
          end else begin
            unique case (q_cmd_i.kind)
              ste_pkg::CMD_LIT: begin
                if (out_free) begin
                  out_valid_d = 1'b1;
                  out_byte_d  = ste_pkg::apply_case(q_cmd_i.data, case_dir);
                  out_error_d = 1'b0;
                  out_last_d  = 1'b1;
                  if (case_active) begin
                    oneshot_d = ste_pkg::CASE_NONE;
                  end
                  q_pop_o = 1'b1;
                  done    = 1'b1;
                end
              end
              ste_pkg::CMD_RAW: begin
                if (out_free) begin
                  out_valid_d = 1'b1;
                  out_byte_d  = q_cmd_i.data;
                  out_error_d = 1'b0;
                  out_last_d  = 1'b1;
                  q_pop_o     = 1'b1;
                  done        = 1'b1;
                end
              end
              ste_pkg::CMD_STICKY: begin
                sticky_d = q_cmd_i.data[1:0];
                q_pop_o  = 1'b1;
                done     = 1'b1;
              end
              ste_pkg::CMD_ONESHOT: begin
                oneshot_d = q_cmd_i.data[1:0];
                q_pop_o   = 1'b1;
                done      = 1'b1;
              end
              ste_pkg::CMD_COPY: begin
                if (!sel_valid || sel_end <= sel_start) begin
                  q_pop_o = 1'b1;
                  done    = 1'b1;
                end else if (sel_end > ste_pkg::SPAN_W'(ste_pkg::MATCH_DEPTH)) begin
                  // span past the store: one error result
                  if (out_free) begin
                    out_valid_d = 1'b1;
                    out_byte_d  = ste_pkg::CH_NUL;
                    out_error_d = 1'b1;
                    out_last_d  = 1'b1;
                    failed_d    = 1'b1;
                    q_pop_o     = 1'b1;
                    done        = 1'b1;
                  end
                end else begin
                  addr_d  = sel_start;
                  end_d   = sel_end;
                  last_d  = q_cmd_i.last;
                  state_d = S_COPY;
                  q_pop_o = 1'b1;
                end
              end
              default: begin
                q_pop_o = 1'b1;
                done    = 1'b1;
              end
            endcase
          end
        end
      end
      S_COPY: begin
        done_last = last_q;
        if (out_free) begin
          out_valid_d = 1'b1;
          if (rd_data_q == ste_pkg::CH_NUL) begin
            out_byte_d  = ste_pkg::CH_NUL;
            out_error_d = 1'b1;
            out_last_d  = 1'b1;
            failed_d    = 1'b1;
            state_d     = S_IDLE;
            done        = 1'b1;
          end else begin
            out_error_d = 1'b0;
            out_last_d  = copy_last;
            if (rd_data_q == ste_pkg::CH_NL) begin
              out_byte_d = ste_pkg::CH_NL;
            end else begin
              out_byte_d = ste_pkg::apply_case(rd_data_q, case_dir);
              if (case_active) begin
                oneshot_d = ste_pkg::CASE_NONE;
              end
            end
            if (copy_last) begin
              state_d = S_IDLE;
              done    = 1'b1;
            end else begin
              addr_d = addr_q + 1'b1;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    // template end: clear modes and failure
    if (done && done_last) begin
      sticky_d  = ste_pkg::CASE_NONE;
      oneshot_d = ste_pkg::CASE_NONE;
      failed_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      match_mem[q_cmd_i.position[ste_pkg::MATCH_AW-1:0]] <= q_cmd_i.data;
    end
    rd_data_q <= match_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      grp_start_q[wr_grp] <= q_cmd_i.span_start;
      grp_end_q[wr_grp]   <= q_cmd_i.span_end;
    end
    addr_q     <= addr_d;
    end_q      <= end_d;
    last_q     <= last_d;
    out_byte_q <= out_byte_d;
    out_error_q <= out_error_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sticky_q    <= ste_pkg::CASE_NONE;
      oneshot_q   <= ste_pkg::CASE_NONE;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
      grp_valid_q <= '0;
    end else begin
      state_q     <= state_d;
      sticky_q    <= sticky_d;
      oneshot_q   <= oneshot_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
      grp_valid_q <= grp_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_error_o = out_error_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== hdl/substitution_template_expander.sv =====
// ----------------------------------------------------------------------------
// substitution_template_expander - replacement template expansion
// Loads matched text and capture group spans, then expands template
// characters into output bytes with group copies and case conversion.
// ----------------------------------------------------------------------------
// Usage: first send the match bytes (tuser 0) and the group spans (tuser 1),
// then the template characters (tuser 2) with tlast on the final one. Each
// output word is one emitted byte; tlast marks the last byte caused by one
// input word, and tuser flags the single word that reports a zero byte
// inside a copied group or a span ending past the store; after either the
// rest of the template is dropped. Timing: the decoder takes one input
// word per cycle, while the queue has room, into a four-entry command
// queue. The executor dispatches a group copy and then streams its bytes,
// paced by the single read port of the match store. Output is registered.
// There is no clearing pass after reset; match bytes read before they are
// written are undefined, and spans not yet written count as invalid.
module substitution_template_expander (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [5:0] position, [13:6] byte_value, [20:14] span_start,
  // [27:21] span_end, [28] span_valid, [31:29] zero
  input  logic [31:0] s_axis_tdata_i,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser_i,
  input  logic        s_axis_tlast_i,   // template_end
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] out_byte
  output logic [7:0]  m_axis_tdata_o,
  // [0] error
  output logic        m_axis_tuser_o,
  output logic        m_axis_tlast_o    // run_last
);

  ste_pkg::cmd_t push_cmd, head_cmd;
  logic          push, full, pop, head_valid;

  // decode words and track escapes
  ste_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_op_i    (s_axis_tuser_i),
    .in_data_i  (s_axis_tdata_i[28:0]),
    .in_last_i  (s_axis_tlast_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_cmd_o    (push_cmd)
  );

  // hold commands between decoder and executor
  ste_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .cmd_o   (head_cmd)
  );

  // execute commands and drive the output word
  ste_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (head_valid),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_error_o (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - self-checking bench for substitution_template_expander
// Loads match bytes and group spans, then streams replacement templates
// through the block. A built-in expansion predictor forms the bytes each
// accepted input word should produce, and the output monitor checks every
// output word against the oldest pending prediction. The sender idles in
// bursts and the receiver stalls on its own changing pattern.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam int         RANDOM_WORDS  = 250;
  localparam int         SETTLE_CYCLES = 100;
  localparam int         REPORT_LIMIT  = 10;
  localparam int         MAX_EMIT      = 64;

  // one input word, unpacked; drain_first holds the word back until every
  // predicted output byte has been seen
  typedef struct {
    logic [1:0]                 op;
    logic [ste_pkg::POS_W-1:0]  pos;
    logic [7:0]                 val;
    logic [ste_pkg::SPAN_W-1:0] st;
    logic [ste_pkg::SPAN_W-1:0] en;
    logic                       vld;
    logic                       tend;
    bit                         drain_first;
  } in_word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       err;
    logic       last;
  } out_word_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i  = '0;
  logic [1:0]  s_axis_tuser_i  = '0;
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;

  substitution_template_expander i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Expansion predictor: its own copy of the match text, spans and modes
  // --------------------------------------------------------------------------
  bit [7:0]                 match_mem [ste_pkg::MATCH_DEPTH];
  bit [ste_pkg::SPAN_W-1:0] span_lo   [ste_pkg::GROUP_COUNT];
  bit [ste_pkg::SPAN_W-1:0] span_hi   [ste_pkg::GROUP_COUNT];
  bit                       span_ok   [ste_pkg::GROUP_COUNT];
  bit                       esc_pending;
  bit [1:0]                 one_shot_mode;
  bit [1:0]                 sticky_mode;
  bit                       dropping;

  out_word_t produced[$];
  out_word_t expected_bytes[$];
  int        predicted_n;

  function automatic void emit_byte(logic [7:0] ch, logic err);
    if (produced.size() < MAX_EMIT) begin
      produced.push_back('{ch: ch, err: err, last: 1'b0});
    end
  endfunction

  // a one-shot mode wins over the sticky one and is used up by any letter
  // or other character that passes through while a mode is active
  function automatic logic [7:0] recase(logic [7:0] c);
    logic [1:0] dir;
    if (one_shot_mode == ste_pkg::CASE_NONE && sticky_mode == ste_pkg::CASE_NONE) begin
      return c;
    end
    dir = (one_shot_mode != ste_pkg::CASE_NONE) ? one_shot_mode : sticky_mode;
    one_shot_mode = ste_pkg::CASE_NONE;
    if (dir == ste_pkg::CASE_LOWER && c >= ste_pkg::CH_UP_A && c <= ste_pkg::CH_UP_Z) begin
      return c + ste_pkg::CASE_DIST;
    end
    if (dir == ste_pkg::CASE_UPPER && c >= ste_pkg::CH_LO_A && c <= ste_pkg::CH_LO_Z) begin
      return c - ste_pkg::CASE_DIST;
    end
    return c;
  endfunction

  function automatic void copy_group(int g);
    int s;
    int e;
    logic [7:0] c;
    if (g >= ste_pkg::GROUP_COUNT) begin
      return;
    end
    if (!span_ok[g]) begin
      return;
    end
    s = span_lo[g];
    e = span_hi[g];
    if (e <= s) begin
      return;
    end
    // a span that runs off the store reads nothing and fails at once
    if (e > ste_pkg::MATCH_DEPTH) begin
      dropping = 1'b1;
      emit_byte(ste_pkg::CH_NUL, 1'b1);
      return;
    end
    for (int a = s; a < e; a++) begin
      c = match_mem[a];
      if (c == ste_pkg::CH_NUL) begin
        dropping = 1'b1;
        emit_byte(ste_pkg::CH_NUL, 1'b1);
        return;
      end
      if (c == ste_pkg::CH_NL) begin
        emit_byte(ste_pkg::CH_NL, 1'b0);
      end else begin
        emit_byte(recase(c), 1'b0);
      end
    end
  endfunction

  function automatic void expand_word(in_word_t w);
    logic [7:0] c;
    produced.delete();
    c = w.val;
    case (w.op)
      ste_pkg::OP_LOAD_BYTE: begin
        match_mem[w.pos] = w.val;
      end
      ste_pkg::OP_LOAD_SPAN: begin
        if (w.pos < ste_pkg::GROUP_COUNT) begin
          span_lo[w.pos] = w.st;
          span_hi[w.pos] = w.en;
          span_ok[w.pos] = w.vld;
        end
      end
      ste_pkg::OP_TEMPLATE: begin
        if (dropping) begin
          // rest of a failed template: drop silently
        end else if (esc_pending) begin
          esc_pending = 1'b0;
          if (c >= ste_pkg::CH_DIG0 && c <= ste_pkg::CH_DIG9) begin
            copy_group(c - ste_pkg::CH_DIG0);
          end else begin
            case (c)
              ste_pkg::CH_NUL:  ;
              ste_pkg::CH_UP_U: sticky_mode   = ste_pkg::CASE_UPPER;
              ste_pkg::CH_UP_L: sticky_mode   = ste_pkg::CASE_LOWER;
              ste_pkg::CH_LO_U: one_shot_mode = ste_pkg::CASE_UPPER;
              ste_pkg::CH_LO_L: one_shot_mode = ste_pkg::CASE_LOWER;
              ste_pkg::CH_UP_E,
              ste_pkg::CH_LO_E: sticky_mode   = ste_pkg::CASE_NONE;
              ste_pkg::CH_LO_B: emit_byte(ste_pkg::CH_BSP, 1'b0);
              ste_pkg::CH_LO_F: emit_byte(ste_pkg::CH_FF, 1'b0);
              ste_pkg::CH_LO_R: emit_byte(ste_pkg::CH_CR, 1'b0);
              ste_pkg::CH_LO_T: emit_byte(ste_pkg::CH_TAB, 1'b0);
              ste_pkg::CH_LO_N: emit_byte(ste_pkg::CH_NL, 1'b0);
              default:          emit_byte(c, 1'b0);
            endcase
          end
        end else begin
          case (c)
            ste_pkg::CH_NUL:    ;
            ste_pkg::CH_BSLASH: esc_pending = 1'b1;
            ste_pkg::CH_AMP:    copy_group(0);
            ste_pkg::CH_NL,
            ste_pkg::CH_CR:     emit_byte(ste_pkg::CH_NL, 1'b0);
            default:            emit_byte(recase(c), 1'b0);
          endcase
        end
        if (w.tend) begin
          esc_pending   = 1'b0;
          one_shot_mode = ste_pkg::CASE_NONE;
          sticky_mode   = ste_pkg::CASE_NONE;
          dropping      = 1'b0;
        end
      end
      default: ;
    endcase
    if (produced.size() > 0) begin
      produced[$].last = 1'b1;
    end
    foreach (produced[i]) begin
      expected_bytes.push_back(produced[i]);
    end
    predicted_n += produced.size();
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus store
  // --------------------------------------------------------------------------
  in_word_t input_words[$];
  int       words_queued;
  bit       drain_next;

  function automatic void send(int op, int pos, int val, int st, int en, int vld, int tend);
    in_word_t w;
    w.op          = 2'(op);
    w.pos         = ste_pkg::POS_W'(pos);
    w.val         = 8'(val);
    w.st          = ste_pkg::SPAN_W'(st);
    w.en          = ste_pkg::SPAN_W'(en);
    w.vld         = 1'(vld);
    w.tend        = 1'(tend);
    w.drain_first = drain_next;
    drain_next    = 1'b0;
    input_words.push_back(w);
    words_queued++;
  endfunction

  // unused fields carry random bits so that every input bit but tdata[31:29] toggles
  function automatic void send_byte(int addr, int value);
    send(ste_pkg::OP_LOAD_BYTE, addr, value, $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic void send_span(int g, int s, int e, int v);
    send(ste_pkg::OP_LOAD_SPAN, g, $urandom, s, e, v, $urandom);
  endfunction

  function automatic void send_char(int c, int tend);
    send(ste_pkg::OP_TEMPLATE, $urandom, c, $urandom, $urandom, $urandom, tend);
  endfunction

  function automatic void send_noise();
    send(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present the head of input_words in bursts with random gaps
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;
  int words_predicted = 0;
  int words_seen      = 0;
  bit stim_done       = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : driver
    bit       accepted;
    bit       present;
    in_word_t w;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      stim_done       <= 1'b0;
    end else begin
      accepted = s_axis_tvalid_i && s_axis_tready_o;
      if (accepted) begin
        expand_word(input_words.pop_front());
      end
      // hold a word that is still waiting for ready
      present = s_axis_tvalid_i && !accepted;
      if (!present) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (input_words.size() > 0 &&
                     (!input_words[0].drain_first || predicted_n == words_seen)) begin
          w = input_words[0];
          present = 1'b1;
          s_axis_tdata_i <= {3'b000, w.vld, w.en, w.st, w.val, w.pos};
          s_axis_tuser_i <= w.op;
          s_axis_tlast_i <= w.tend;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end
      end
      s_axis_tvalid_i <= present;
      words_predicted <= predicted_n;
      stim_done       <= (input_words.size() == 0) && !present;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each output word, stall ready on a shifting pattern
  // --------------------------------------------------------------------------
  int fail_count  = 0;
  int stall_mode  = 0;
  int stall_count = 0;

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_word_t want;
    bit        ready_next;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_bytes.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: unexpected word: byte %02h err %b last %b", $realtime,
                     m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
          end
        end else begin
          want = expected_bytes.pop_front();
          words_seen <= words_seen + 1;
          if (m_axis_tdata_o !== want.ch || m_axis_tuser_o !== want.err ||
              m_axis_tlast_o !== want.last) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("%0t: mismatch: got byte %02h err %b last %b, want byte %02h err %b last %b",
                       $realtime, m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o,
                       want.ch, want.err, want.last);
            end
          end
        end
      end
      // now and then pick a new stall pattern at random
      stall_count++;
      if (stall_count % 50 == 0) begin
        stall_mode = $urandom_range(0, 3);
      end
      case (stall_mode)
        0:       ready_next = 1'b1;
        1:       ready_next = $urandom_range(0, 1);
        2:       ready_next = ($urandom_range(0, 3) == 0);
        default: ready_next = stall_count[1];
      endcase
      m_axis_tready_i <= ready_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int         k;
    int         n;
    int         g;
    int         s;
    int         e;
    int         target;
    bit         ended;
    logic [7:0] chars[$];
    logic [7:0] case_codes[6];
    logic [7:0] ctrl_codes[5];

    case_codes = '{ste_pkg::CH_UP_U, ste_pkg::CH_UP_L, ste_pkg::CH_LO_U,
                   ste_pkg::CH_LO_L, ste_pkg::CH_UP_E, ste_pkg::CH_LO_E};
    ctrl_codes = '{ste_pkg::CH_LO_B, ste_pkg::CH_LO_F, ste_pkg::CH_LO_R,
                   ste_pkg::CH_LO_T, ste_pkg::CH_LO_N};

    // directed: store extremes, a newline and a zero inside the text
    send_byte(0, "a");
    send_byte(1, "B");
    send_byte(2, ste_pkg::CH_NL);
    send_byte(3, ste_pkg::CH_NUL);
    send_byte(ste_pkg::MATCH_DEPTH - 1, 8'hFF);
    send_span(0, 0, 3, 1);
    send_span(1, 0, 4, 1);                      // runs into the zero byte
    send_span(ste_pkg::GROUP_COUNT - 1, ste_pkg::MATCH_DEPTH - 1, ste_pkg::MATCH_DEPTH, 1);
    send_span(3, 0, 100, 1);                    // ends past the store
    send_noise();
    // one-shot upper on a group copy with a newline in it
    send_char(ste_pkg::CH_BSLASH, 0);
    send_char(ste_pkg::CH_LO_U, 0);
    send_char(ste_pkg::CH_AMP, 1);
    // sticky lower on a literal, cleared by the template end
    send_char(ste_pkg::CH_BSLASH, 0);
    send_char(ste_pkg::CH_UP_L, 0);
    send_char("Q", 1);
    // last group, CR, zero inside a group, then a dropped tail
    send_char(ste_pkg::CH_BSLASH, 0);
    send_char(ste_pkg::CH_DIG9, 0);
    send_char(ste_pkg::CH_CR, 0);
    send_char(ste_pkg::CH_BSLASH, 0);
    send_char(ste_pkg::CH_DIG0 + 1, 0);
    send_char("z", 1);
    // lone trailing backslash
    send_char(ste_pkg::CH_BSLASH, 1);
    // span past the store
    send_char(ste_pkg::CH_BSLASH, 0);
    send_char(ste_pkg::CH_DIG0 + 3, 1);

    target = RANDOM_WORDS;

    // fill the whole store after a full drain, then copy all of it once
    drain_next = 1'b1;
    for (int a = 0; a < ste_pkg::MATCH_DEPTH; a++) begin
      send_byte(a, $urandom_range(1, 255));
    end
    send_span(0, 0, ste_pkg::MATCH_DEPTH, 1);
    send_char(ste_pkg::CH_AMP, 1);

    // random sessions: a few loads, then one template
    while (words_queued < target) begin
      if ($urandom_range(0, 9) == 0) begin
        drain_next = 1'b1;
      end
      repeat ($urandom_range(0, 5)) begin
        k = $urandom_range(0, 19);
        send_byte($urandom_range(0, ste_pkg::MATCH_DEPTH - 1),
                  (k == 0) ? ste_pkg::CH_NUL :
                  (k == 1) ? ste_pkg::CH_NL : $urandom_range(1, 255));
      end
      repeat ($urandom_range(0, 3)) begin
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(ste_pkg::GROUP_COUNT, 63)
                                        : $urandom_range(0, ste_pkg::GROUP_COUNT - 1);
        k = $urandom_range(0, 19);
        if (k < 2) begin
          s = $urandom_range(0, 127);
          e = $urandom_range(0, 127);
        end else begin
          s = $urandom_range(0, ste_pkg::MATCH_DEPTH - 1);
          e = (k == 2) ? $urandom_range(s, ste_pkg::MATCH_DEPTH) : s + $urandom_range(0, 8);
        end
        send_span(g, s, e, $urandom_range(0, 6) != 0);
      end
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end
      chars.delete();
      n = $urandom_range(1, 10);
      repeat (n) begin
        k = $urandom_range(0, 19);
        if (k < 6) begin
          chars.push_back(8'($urandom));
        end else if (k < 9) begin
          chars.push_back(ste_pkg::CH_AMP);
        end else if (k < 10) begin
          chars.push_back($urandom_range(0, 1) ? ste_pkg::CH_NL : ste_pkg::CH_CR);
        end else if (k < 11) begin
          chars.push_back(ste_pkg::CH_NUL);
        end else begin
          chars.push_back(ste_pkg::CH_BSLASH);
          k = $urandom_range(0, 9);
          if (k < 4) begin
            chars.push_back(8'(ste_pkg::CH_DIG0 + $urandom_range(0, 9)));
          end else if (k < 7) begin
            chars.push_back(case_codes[$urandom_range(0, 5)]);
          end else if (k < 9) begin
            chars.push_back(ctrl_codes[$urandom_range(0, 4)]);
          end else begin
            chars.push_back(8'($urandom));
          end
        end
      end
      // most templates end properly; some run on into the next session
      ended = $urandom_range(0, 9) != 0;
      if (ended && $urandom_range(0, 14) == 0) begin
        chars.push_back(ste_pkg::CH_BSLASH);
      end
      foreach (chars[i]) begin
        send_char(chars[i], ended && i == chars.size() - 1);
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for the last word to go in and every predicted byte to come out
    @(posedge clk_i);
    while (!(stim_done && words_seen == words_predicted)) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && expected_bytes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #6_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== substitution_template_expander.f =====
hdl/ste_pkg.sv
hdl/ste_front.sv
hdl/ste_cmd_fifo.sv
hdl/ste_back.sv
hdl/substitution_template_expander.sv
tb/testbench.sv
